[rtl/crank_dip_capture_top_assert.svh]
// Assertion macros for the crank dip capture block.
// Both expect clk and rst_n in the scope of use.
`ifndef CRANK_DIP_CAPTURE_TOP_ASSERT_SVH
`define CRANK_DIP_CAPTURE_TOP_ASSERT_SVH

`define CRKDIP_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("crank dip capture assertion failed");

`define CRKDIP_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("crank dip capture assertion failed");

`endif

[rtl/crkdip_pkg.sv]
`timescale 1ns / 1ps
package crkdip_pkg;

  typedef logic [7:0]  sample_t;
  typedef logic [15:0] scaled_t;
  typedef logic [23:0] product_t;
  typedef logic [1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_FIRST_COUNT  = 2'd0;
  localparam cfg_idx_t CFG_SECOND_COUNT = 2'd1;
  localparam cfg_idx_t CFG_FULL_SCALE   = 2'd2;

  localparam sample_t FIRST_COUNT_RST  = 8'd20;
  localparam sample_t SECOND_COUNT_RST = 8'd60;
  localparam scaled_t FULL_SCALE_RST   = 16'd1500;
  localparam sample_t MIN_INIT         = 8'hFF;

  // ceil(2^16 / 10), exact for magnitudes up to 4095
  localparam logic [12:0] SLOPE_RECIP = 13'd6554;

  localparam logic CMD_TRIGGER = 1'b0;
  localparam logic CMD_SAMPLE  = 1'b1;

  typedef struct packed {
    sample_t first_count;
    sample_t second_count;
    scaled_t full_scale;
  } cfg_t;

  typedef struct packed {
    sample_t  first_raw;
    sample_t  second_raw;
    product_t first_prod;
    product_t second_prod;
  } res_t;

endpackage

[rtl/crkdip_in_if.sv]
`timescale 1ns / 1ps
interface crkdip_in_if
  import crkdip_pkg::*;
;
  logic    valid;
  logic    ready;
  logic    cmd;
  sample_t sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink (input valid, input cmd, input sample, output ready);
endinterface

[rtl/crkdip_out_if.sv]
`timescale 1ns / 1ps
interface crkdip_out_if
  import crkdip_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t first_min_raw;
  sample_t second_min_raw;
  scaled_t first_min_scaled;
  scaled_t second_min_scaled;

  modport source (output valid, output first_min_raw, output second_min_raw,
                  output first_min_scaled, output second_min_scaled, input ready);
  modport sink (input valid, input first_min_raw, input second_min_raw,
                input first_min_scaled, input second_min_scaled, output ready);
endinterface

[rtl/crkdip_cfg_if.sv]
`timescale 1ns / 1ps
interface crkdip_cfg_if
  import crkdip_pkg::*;
;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  scaled_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/crkdip_core.sv]
`timescale 1ns / 1ps
`include "crank_dip_capture_top_assert.svh"
module crkdip_core
  import crkdip_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  logic    item_cmd,
  input  sample_t item_sample,
  output logic    item_take,
  input  logic    res_ready,
  output logic    res_valid,
  output res_t    res_data
);

  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SLOPE, PH_SECOND} phase_t;

  phase_t             phase_r, phase_nxt;
  sample_t            count_r, count_nxt;
  sample_t            min1_r, min1_nxt;
  sample_t            min2_r, min2_nxt;
  sample_t            held_r, held_nxt;
  logic               toggle_r, toggle_nxt;
  logic signed [9:0]  slope_r, slope_nxt;
  logic               a_valid_r, a_valid_nxt;
  res_t               a_data_r, a_data_nxt;

  logic               a_ready;
  sample_t            count_inc;
  sample_t            min1_new;
  sample_t            min2_new;
  logic signed [8:0]  dx;
  logic        [12:0] sum;
  logic        [12:0] mag;
  logic        [24:0] quot_prod;
  logic        [8:0]  quot;
  logic        [9:0]  slope_new;

  assign a_ready   = !a_valid_r || res_ready;
  assign item_take = item_valid && a_ready;
  assign res_valid = a_valid_r;
  assign res_data  = a_data_r;

  assign count_inc = count_r + 8'd1;
  assign min1_new  = (item_sample < min1_r) ? item_sample : min1_r;
  assign min2_new  = (item_sample < min2_r) ? item_sample : min2_r;

  // slope filter: (2*dx + 8*slope) / 10, truncated toward zero
  assign dx        = $signed({1'b0, item_sample}) - $signed({1'b0, held_r});
  assign sum       = {{3{dx[8]}}, dx, 1'b0} + {slope_r, 3'b000};
  assign mag       = sum[12] ? (13'd0 - sum) : sum;
  assign quot_prod = {13'd0, mag[11:0]} * {12'd0, SLOPE_RECIP};
  assign quot      = quot_prod[24:16];
  assign slope_new = sum[12] ? (10'd0 - {1'b0, quot}) : {1'b0, quot};

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    min1_nxt    = min1_r;
    min2_nxt    = min2_r;
    held_nxt    = held_r;
    toggle_nxt  = toggle_r;
    slope_nxt   = slope_r;
    a_valid_nxt = a_valid_r && !res_ready;
    a_data_nxt  = a_data_r;
    if (item_take) begin
      if (item_cmd == CMD_TRIGGER) begin
        if (phase_r == PH_IDLE) begin
          phase_nxt  = PH_FIRST;
          count_nxt  = 8'd0;
          min1_nxt   = MIN_INIT;
          min2_nxt   = MIN_INIT;
          toggle_nxt = 1'b0;
          slope_nxt  = '0;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_FIRST: begin
            min1_nxt  = min1_new;
            count_nxt = count_inc;
            if (count_inc == cfg.first_count) begin
              phase_nxt  = PH_SLOPE;
              count_nxt  = 8'd0;
              toggle_nxt = 1'b0;
            end
          end
          PH_SLOPE: begin
            if (!toggle_r) begin
              held_nxt   = item_sample;
              toggle_nxt = 1'b1;
            end else begin
              slope_nxt  = $signed(slope_new);
              toggle_nxt = 1'b0;
              if (slope_new[9]) begin
                phase_nxt = PH_SECOND;
                count_nxt = 8'd0;
              end
            end
          end
          PH_SECOND: begin
            min2_nxt  = min2_new;
            count_nxt = count_inc;
            if (count_inc == cfg.second_count) begin
              a_valid_nxt            = 1'b1;
              a_data_nxt.first_raw   = min1_r;
              a_data_nxt.second_raw  = min2_new;
              a_data_nxt.first_prod  = {16'd0, min1_r} * {8'd0, cfg.full_scale};
              a_data_nxt.second_prod = {16'd0, min2_new} * {8'd0, cfg.full_scale};
              phase_nxt              = PH_IDLE;
              count_nxt              = 8'd0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      count_r   <= 8'd0;
      min1_r    <= MIN_INIT;
      min2_r    <= MIN_INIT;
      held_r    <= 8'd0;
      toggle_r  <= 1'b0;
      slope_r   <= '0;
      a_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      min1_r    <= min1_nxt;
      min2_r    <= min2_nxt;
      held_r    <= held_nxt;
      toggle_r  <= toggle_nxt;
      slope_r   <= slope_nxt;
      a_valid_r <= a_valid_nxt;
    end
    a_data_r <= a_data_nxt;
  end

  `CRKDIP_ASSERT_IMP(a_idle_count_zero, phase_r == PH_IDLE, count_r == 8'd0)
  `CRKDIP_ASSERT_IMP(a_toggle_in_slope, phase_r != PH_SLOPE, !toggle_r)
  `CRKDIP_ASSERT_IMP(a_slope_range, 1'b1, (slope_r >= -10'sd255) && (slope_r <= 10'sd255))
  `CRKDIP_ASSERT_NXT(a_result_to_idle, item_take && (a_valid_nxt && !(a_valid_r && !res_ready)),
                     phase_r == PH_IDLE)

endmodule

[rtl/crkdip_scale.sv]
`timescale 1ns / 1ps
module crkdip_scale
  import crkdip_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  res_t                res_data,
  output logic                res_ready,
  crkdip_out_if.source        out_ch
);

  logic    b_valid_r;
  sample_t first_raw_r, second_raw_r;
  scaled_t first_scaled_r, second_scaled_r;

  // x / 255 as x * 0x01010102 >> 32, exact for x below 255 * 65536 (any 8 bit by 16 bit product)
  function automatic scaled_t div255(input product_t x);
    logic [55:0] xe;
    logic [55:0] acc;
    xe  = {32'd0, x};
    acc = (xe << 24) + (xe << 16) + (xe << 8) + (xe << 1);
    return acc[47:32];
  endfunction

  assign res_ready = !b_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (res_ready) begin
      b_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      first_raw_r     <= res_data.first_raw;
      second_raw_r    <= res_data.second_raw;
      first_scaled_r  <= div255(res_data.first_prod);
      second_scaled_r <= div255(res_data.second_prod);
    end
  end

  assign out_ch.valid             = b_valid_r;
  assign out_ch.first_min_raw     = first_raw_r;
  assign out_ch.second_min_raw    = second_raw_r;
  assign out_ch.first_min_scaled  = first_scaled_r;
  assign out_ch.second_min_scaled = second_scaled_r;

endmodule

[rtl/crank_dip_capture_top.sv]
// Crank dip capture: one item accepted per cycle unless out_ch backpressure stalls it.
// A result reaches out_ch after the transfer of the last phase-three sample
// via the input register, the min/product stage and then the divide stage.
// Throughput limited only by out_ch backpressure through the two result stages.
// Reset (synchronous, rst_n low): idle, minima 255, counts 20/60, full scale 1500.
`timescale 1ns / 1ps
module crank_dip_capture_top
  import crkdip_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  crkdip_in_if.sink    in_ch,
  crkdip_out_if.source out_ch,
  crkdip_cfg_if.sink   cfg_ch
);

  cfg_t    cfg_r;
  logic    in_valid_r;
  logic    in_cmd_r;
  sample_t in_sample_r;
  logic    item_take;
  logic    res_valid;
  logic    res_ready;
  res_t    res_data;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !in_valid_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_count  <= FIRST_COUNT_RST;
      cfg_r.second_count <= SECOND_COUNT_RST;
      cfg_r.full_scale   <= FULL_SCALE_RST;
      in_valid_r         <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_FIRST_COUNT:  cfg_r.first_count  <= cfg_ch.data[7:0];
          CFG_SECOND_COUNT: cfg_r.second_count <= cfg_ch.data[7:0];
          CFG_FULL_SCALE:   cfg_r.full_scale   <= cfg_ch.data;
          default: begin
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (item_take) begin
        in_valid_r <= 1'b0;
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      in_cmd_r    <= in_ch.cmd;
      in_sample_r <= in_ch.sample;
    end
  end

  crkdip_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .item_valid  (in_valid_r),
    .item_cmd    (in_cmd_r),
    .item_sample (in_sample_r),
    .item_take   (item_take),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  crkdip_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

[dv/crank_dip_capture_top_tb.sv]
`timescale 1ns / 1ps
module crank_dip_capture_top_tb;
  import crkdip_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FIRST, ST_SLOPE, ST_SECOND} capture_phase_e;

  typedef struct packed {
    sample_t first_raw;
    sample_t second_raw;
    scaled_t first_scaled;
    scaled_t second_scaled;
  } dip_t;

  logic clk;
  logic rst_n;

  crkdip_in_if  in_ch();
  crkdip_out_if out_ch();
  crkdip_cfg_if cfg_ch();

  crank_dip_capture_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted block state and register copies
  capture_phase_e phase_q;
  sample_t        count_q;
  sample_t        first_min_q;
  sample_t        second_min_q;
  sample_t        held_q;
  logic           toggle_q;
  int             slope_q;
  sample_t        first_count_q;
  sample_t        second_count_q;
  scaled_t        full_scale_q;

  dip_t expected_dips[$];
  dip_t want_dip;
  dip_t got_dip;
  int   mismatches;
  int   hold_left;
  bit   steady;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("crank_dip_capture_top: mismatch");
    $finish;
  end

  function automatic scaled_t scale_min(sample_t raw);
    product_t prod;
    prod = product_t'(raw) * product_t'(full_scale_q);
    return scaled_t'(prod / product_t'(255));
  endfunction

  task automatic predict_capture(logic c, sample_t s);
    int   dx;
    int   acc;
    dip_t r;
    if (c == CMD_TRIGGER) begin
      if (phase_q == ST_IDLE) begin
        phase_q      = ST_FIRST;
        count_q      = '0;
        first_min_q  = MIN_INIT;
        second_min_q = MIN_INIT;
        toggle_q     = 1'b0;
        slope_q      = 0;
      end
      return;
    end
    case (phase_q)
      ST_FIRST: begin
        if (s < first_min_q) first_min_q = s;
        count_q = count_q + 8'd1;
        if (count_q == first_count_q) begin
          phase_q  = ST_SLOPE;
          count_q  = '0;
          toggle_q = 1'b0;
        end
      end
      ST_SLOPE: begin
        if (!toggle_q) begin
          held_q   = s;
          toggle_q = 1'b1;
        end else begin
          dx       = int'(s) - int'(held_q);
          acc      = 2 * dx + 8 * slope_q;
          slope_q  = acc / 10;
          toggle_q = 1'b0;
          if (slope_q < 0) begin
            phase_q = ST_SECOND;
            count_q = '0;
          end
        end
      end
      ST_SECOND: begin
        if (s < second_min_q) second_min_q = s;
        count_q = count_q + 8'd1;
        if (count_q == second_count_q) begin
          r.first_raw     = first_min_q;
          r.second_raw    = second_min_q;
          r.first_scaled  = scale_min(first_min_q);
          r.second_scaled = scale_min(second_min_q);
          expected_dips.push_back(r);
          phase_q = ST_IDLE;
          count_q = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(string what, dip_t want, dip_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected raw %0d/%0d scaled %0d/%0d, got raw %0d/%0d scaled %0d/%0d",
               $time, what, want.first_raw, want.second_raw, want.first_scaled,
               want.second_scaled, got.first_raw, got.second_raw, got.first_scaled,
               got.second_scaled);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_dip.first_raw     = out_ch.first_min_raw;
      got_dip.second_raw    = out_ch.second_min_raw;
      got_dip.first_scaled  = out_ch.first_min_scaled;
      got_dip.second_scaled = out_ch.second_min_scaled;
      if (expected_dips.size() == 0) begin
        note_mismatch("unexpected result", '0, got_dip);
      end else begin
        want_dip = expected_dips.pop_front();
        if (got_dip.first_raw !== want_dip.first_raw ||
            got_dip.second_raw !== want_dip.second_raw ||
            got_dip.first_scaled !== want_dip.first_scaled ||
            got_dip.second_scaled !== want_dip.second_scaled) begin
          note_mismatch("result", want_dip, got_dip);
        end
      end
    end
  end

  // result sink: random stalls plus requested long hold-offs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 6);
    end
  end

  task automatic send_item(logic c, sample_t s);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= c;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    predict_capture(c, s);
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    quiet_input();
    wait (expected_dips.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic finish_capture();
    while (phase_q != ST_IDLE) begin
      if (phase_q == ST_SLOPE) send_item(CMD_SAMPLE, toggle_q ? 8'd0 : 8'd255);
      else send_item(CMD_SAMPLE, sample_t'($urandom_range(255)));
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, scaled_t data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_FIRST_COUNT:  first_count_q  = data[7:0];
      CFG_SECOND_COUNT: second_count_q = data[7:0];
      CFG_FULL_SCALE:   full_scale_q   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(int first_n, int second_n, int fs);
    finish_capture();
    drain_results();
    write_reg(CFG_FIRST_COUNT, scaled_t'(first_n));
    write_reg(CFG_SECOND_COUNT, scaled_t'(second_n));
    write_reg(CFG_FULL_SCALE, scaled_t'(fs));
  endtask

  task automatic capture_run(int noise_pct);
    int pairs;
    pairs = 0;
    send_item(CMD_TRIGGER, sample_t'($urandom_range(255)));
    while (phase_q != ST_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        send_item(logic'($urandom_range(1)), sample_t'($urandom_range(255)));
      end else if (phase_q == ST_SLOPE && pairs > 24) begin
        send_item(CMD_SAMPLE, toggle_q ? 8'd0 : 8'd255);
      end else begin
        if (phase_q == ST_SLOPE) pairs++;
        send_item(CMD_SAMPLE, sample_t'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_reset_settings();
    capture_run(0);
  endtask

  task automatic test_directed();
    set_regs(2, 2, 65535);
    send_item(CMD_SAMPLE, 8'd0);
    send_item(CMD_SAMPLE, 8'd255);
    send_item(CMD_TRIGGER, 8'd0);
    send_item(CMD_TRIGGER, 8'd255);
    send_item(CMD_SAMPLE, 8'd255);
    send_item(CMD_SAMPLE, 8'd0);
    send_item(CMD_SAMPLE, 8'd100);
    send_item(CMD_SAMPLE, 8'd100);
    send_item(CMD_TRIGGER, 8'd0);
    // small negative sum truncates to zero, stays in slope watch
    send_item(CMD_SAMPLE, 8'd10);
    send_item(CMD_SAMPLE, 8'd9);
    send_item(CMD_SAMPLE, 8'd0);
    send_item(CMD_SAMPLE, 8'd255);
    send_item(CMD_SAMPLE, 8'd255);
    send_item(CMD_SAMPLE, 8'd0);
    send_item(CMD_SAMPLE, 8'd170);
    send_item(CMD_TRIGGER, 8'd0);
    send_item(CMD_SAMPLE, 8'd85);
    send_item(CMD_SAMPLE, 8'd42);
    send_item(CMD_TRIGGER, 8'd0);
    send_item(CMD_SAMPLE, 8'd255);
    send_item(CMD_SAMPLE, 8'd255);
    send_item(CMD_SAMPLE, 8'd255);
    send_item(CMD_SAMPLE, 8'd0);
    send_item(CMD_SAMPLE, 8'd255);
    send_item(CMD_SAMPLE, 8'd0);
  endtask

  task automatic test_count_extremes();
    set_regs(0, 255, 0);
    capture_run(3);
    set_regs(255, 0, 65535);
    capture_run(3);
  endtask

  task automatic test_short_runs();
    int fs;
    for (int i = 0; i < 12; i++) begin
      if (i % 8 == 0) begin
        case ($urandom_range(3))
          0: fs = FULL_SCALE_RST;
          1: fs = 255;
          default: fs = $urandom_range(65535);
        endcase
        set_regs($urandom_range(1, 6), $urandom_range(1, 6), fs);
      end
      repeat ($urandom_range(2)) send_item(CMD_SAMPLE, sample_t'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        repeat (8) send_item(logic'($urandom_range(1)), sample_t'($urandom_range(255)));
        finish_capture();
      end else begin
        capture_run(8);
      end
    end
  endtask

  task automatic test_backpressure();
    set_regs(1, 1, $urandom_range(65535));
    hold_left = 300;
    repeat (12) capture_run(0);
    drain_results();
    repeat (4) capture_run(0);
  endtask

  task automatic test_steady();
    set_regs($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(65535));
    steady = 1'b1;
    repeat (10) capture_run(5);
    steady = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_TRIGGER;
    in_ch.sample   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_FIRST_COUNT;
    cfg_ch.data    = '0;
    out_ch.ready   = 1'b0;
    mismatches     = 0;
    hold_left      = 0;
    steady         = 1'b0;
    phase_q        = ST_IDLE;
    count_q        = '0;
    first_min_q    = MIN_INIT;
    second_min_q   = MIN_INIT;
    held_q         = '0;
    toggle_q       = 1'b0;
    slope_q        = 0;
    first_count_q  = FIRST_COUNT_RST;
    second_count_q = SECOND_COUNT_RST;
    full_scale_q   = FULL_SCALE_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_directed();
    test_count_extremes();
    test_short_runs();
    test_backpressure();
    test_steady();
    finish_capture();

    quiet_input();
    wait (expected_dips.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_dips.size() == 0) begin
      $display("crank_dip_capture_top: match");
    end else begin
      $display("crank_dip_capture_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/crkdip_pkg.sv
rtl/crkdip_in_if.sv
rtl/crkdip_out_if.sv
rtl/crkdip_cfg_if.sv
rtl/crkdip_core.sv
rtl/crkdip_scale.sv
rtl/crank_dip_capture_top.sv
dv/crank_dip_capture_top_tb.sv
